[src/lz77fg_pkg.sv]
package lz77fg_pkg;

  localparam int WINDOW     = 1024;
  localparam int GROUP      = 8;
  localparam int HIST_DEPTH = 2 * WINDOW;
  localparam int HAW        = $clog2(HIST_DEPTH);
  localparam int WAW        = $clog2(WINDOW);
  localparam int DW         = WAW + 1;
  localparam int GW         = $clog2(GROUP);
  localparam int CW         = GW + 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    logic          is_match;
    logic [DW-1:0] offset;
    logic [DW-1:0] length;
    logic [7:0]    next;
  } token_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_TAIL,
    ST_TOKEN,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    PART_OFF_LO,
    PART_OFF_HI,
    PART_LEN_LO,
    PART_LEN_HI,
    PART_NEXT
  } part_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic token;
    logic flush_step;
  } dp_cmd_t;

  typedef struct packed {
    logic in_window;
    logic sweep_done;
    logic flush_needed;
    logic emit_final;
    logic out_free;
  } dp_sts_t;

endpackage

[src/lz77fg_ctrl.sv]
module lz77fg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lz77fg_pkg::dp_sts_t sts,
  output lz77fg_pkg::dp_cmd_t cmd,
  output lz77fg_pkg::state_t  state
);
  import lz77fg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_window ? ST_SWEEP : ST_TOKEN;
        end
      end
      ST_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_TOKEN;
      end
      ST_TOKEN: begin
        state_nxt = sts.flush_needed ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts.out_free && sts.emit_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SWEEP: cmd.issue = 1'b1;
      ST_TOKEN: cmd.token = 1'b1;
      ST_FLUSH: cmd.flush_step = sts.out_free;
      default: cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

[src/lz77fg_dp.sv]
module lz77fg_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lz77fg_pkg::in_beat_t  in_data,
  input  lz77fg_pkg::dp_cmd_t   cmd,
  output lz77fg_pkg::dp_sts_t   sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lz77fg_pkg::out_beat_t out_data
);
  import lz77fg_pkg::*;

  logic [7:0]    hist_mem  [HIST_DEPTH];
  logic          alive_mem [WINDOW];

  logic [7:0]    byte_r;
  logic          last_r;
  logic [DW-1:0] seen_r;
  logic [HAW-1:0] ws_r;
  logic          active_r;
  logic [DW-1:0] ml_r;
  logic [DW-1:0] d_r;
  logic          cmp_v_r;
  logic [DW-1:0] cmp_d_r;
  logic [7:0]    hist_q_r;
  logic          alive_q_r;
  logic          any_r;
  logic [DW-1:0] best_r;
  logic [DW-1:0] prev_best_r;
  token_t        tokens_r [GROUP];
  logic [CW-1:0] count_r;
  logic [GROUP-1:0] flags_r;
  logic          e_flag_r;
  logic [GW-1:0] e_idx_r;
  part_t         e_part_r;
  logic          out_valid_r;
  out_beat_t     out_r;

  logic          in_window;
  logic          keep;
  logic          tok_add;
  token_t        tok;
  token_t        cur;
  logic [GW-1:0] idx_inc;
  logic [7:0]    emit_byte;
  logic          emit_final;
  logic          out_free;

  assign in_window = (seen_r == DW'(WINDOW));
  assign keep = (active_r ? alive_q_r : 1'b1) && (cmp_d_r > ml_r) && (hist_q_r == byte_r);
  assign tok_add = !in_window || !any_r || last_r;
  assign out_free = !out_valid_r || !out_stall;
  assign cur = tokens_r[e_idx_r];
  assign idx_inc = e_idx_r + 1'b1;
  assign emit_final = !e_flag_r && (e_part_r == PART_NEXT)
                      && ({1'b0, e_idx_r} == count_r - 1'b1);

  always_comb begin
    tok = '0;
    if (!in_window) begin
      tok.next = byte_r;
    end else if (any_r) begin
      tok.is_match = 1'b1;
      tok.offset   = best_r;
      tok.length   = ml_r + 1'b1;
    end else if (ml_r == '0) begin
      tok.next = byte_r;
    end else begin
      tok.is_match = 1'b1;
      tok.offset   = prev_best_r;
      tok.length   = ml_r;
      tok.next     = byte_r;
    end
  end

  always_comb begin
    emit_byte = 8'h00;
    if (e_flag_r) begin
      emit_byte = 8'(flags_r);
    end else begin
      case (e_part_r)
        PART_OFF_LO: emit_byte = cur.offset[7:0];
        PART_OFF_HI: emit_byte = 8'(cur.offset >> 8);
        PART_LEN_LO: emit_byte = cur.length[7:0];
        PART_LEN_HI: emit_byte = 8'(cur.length >> 8);
        PART_NEXT:   emit_byte = cur.next;
        default:     emit_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      hist_q_r  <= hist_mem[ws_r - HAW'(d_r)];
      alive_q_r <= alive_mem[WAW'(d_r - 1'b1)];
    end
    if (cmp_v_r) begin
      alive_mem[WAW'(cmp_d_r - 1'b1)] <= keep;
    end
    if (cmd.token) begin
      hist_mem[ws_r] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data.data_byte;
    end
    if (cmd.issue) begin
      cmp_d_r <= d_r;
    end
    if (cmp_v_r && keep) begin
      best_r <= cmp_d_r;
    end
    if (cmd.token && in_window && any_r) begin
      prev_best_r <= best_r;
    end
    if (cmd.token && tok_add) begin
      tokens_r[count_r[GW-1:0]] <= tok;
    end
    if (cmd.flush_step) begin
      out_r <= '{out_byte: emit_byte, run_last: emit_final};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 1'b0;
      seen_r      <= '0;
      ws_r        <= '0;
      active_r    <= 1'b0;
      ml_r        <= '0;
      d_r         <= '0;
      cmp_v_r     <= 1'b0;
      any_r       <= 1'b0;
      count_r     <= '0;
      flags_r     <= '0;
      e_flag_r    <= 1'b0;
      e_idx_r     <= '0;
      e_part_r    <= PART_OFF_LO;
      out_valid_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.issue;
      if (cmd.load) begin
        last_r <= in_data.end_of_input;
        d_r    <= DW'(1);
        any_r  <= 1'b0;
      end
      if (cmd.issue) begin
        d_r <= d_r + 1'b1;
      end
      if (cmp_v_r && keep) begin
        any_r <= 1'b1;
      end
      if (cmd.token) begin
        ws_r <= ws_r + 1'b1;
        if (!in_window) begin
          seen_r <= seen_r + 1'b1;
        end else if (any_r) begin
          ml_r     <= ml_r + 1'b1;
          active_r <= !last_r;
        end else begin
          ml_r     <= '0;
          active_r <= 1'b0;
        end
        if (tok_add) begin
          flags_r[count_r[GW-1:0]] <= tok.is_match;
          count_r <= count_r + 1'b1;
        end
        e_flag_r <= 1'b1;
        e_idx_r  <= '0;
      end
      if (cmd.flush_step) begin
        if (e_flag_r) begin
          e_flag_r <= 1'b0;
          e_part_r <= tokens_r[0].is_match ? PART_OFF_LO : PART_NEXT;
        end else if (e_part_r != PART_NEXT) begin
          e_part_r <= part_t'(e_part_r + 1'b1);
        end else begin
          e_idx_r  <= idx_inc;
          e_part_r <= tokens_r[idx_inc].is_match ? PART_OFF_LO : PART_NEXT;
        end
        if (emit_final) begin
          count_r <= '0;
          flags_r <= '0;
          if (last_r) begin
            seen_r   <= '0;
            ws_r     <= '0;
            active_r <= 1'b0;
            ml_r     <= '0;
          end
        end
      end
      if (cmd.flush_step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_window    = in_window;
  assign sts.sweep_done   = (d_r == DW'(WINDOW));
  assign sts.flush_needed = tok_add && ((count_r == CW'(GROUP - 1)) || last_r);
  assign sts.emit_final   = emit_final;
  assign sts.out_free     = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/lz77_flag_group_encoder.sv]
// LZ77 encoder with a 1024-byte window, tokens grouped eight behind a flag byte.
// Input channel: in_valid/in_stall carry one raw byte a beat; end_of_input
// marks the final byte of a stream. Output channel: out_valid/out_stall carry
// one compressed byte a beat; run_last marks the final byte caused by an input.
// A byte among the first 1024 of a stream passes the idle and token states.
// From then on every byte walks all 1024 candidate offsets through the history
// and candidate memories, one offset a cycle on their single read ports, before
// its token is formed. When a group of eight tokens completes, or the stream
// ends, the group's flag and token bytes (up to 41) leave one per cycle while
// out_stall is low, before the next byte is taken.
// The output register keeps the last byte on offer while the next byte is
// accepted; out_stall holds that register and, during a group burst, the
// burst itself. After end_of_input all stream state clears and the next byte
// starts a new stream.
// Reset (rst_n low, synchronous) returns to idle with an empty stream; the
// memories need no clearing pass.
module lz77_flag_group_encoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lz77fg_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lz77fg_pkg::out_beat_t out_data
);
  import lz77fg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  state_t  state;

  lz77fg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  lz77fg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while an item is in work");

  a_flush_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_FLUSH && sts.out_free) |=> out_valid)
    else $error("burst step lost its output byte");

  a_stall_no_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.flush_step)
    else $error("output byte overwritten while stalled");
`endif

endmodule
